/* src/rxsd_pkg.sv */
// ----------------------------------------------------------------------------
// rxsd_pkg
// shared types and constants for the rolling xor string decoder
// ----------------------------------------------------------------------------
package rxsd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned PAD_W   = 4;
  localparam int unsigned KIND_W  = 2;

  localparam logic [BYTE_W-1:0] HDR_SIGNED_MAX = 8'd8;
  localparam logic [PAD_W-1:0]  PAD_RESET      = 4'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_BODY = 2'd0,
    KIND_PAD  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR1 = 3'd1,
    PH_HDR2 = 3'd2,
    PH_HDR3 = 3'd3,
    PH_BODY = 3'd4
  } phase_t;

  // what one accepted item asks the output side to emit
  typedef struct packed {
    logic              err;
    logic              has_body;
    logic              body_last;
    logic [BYTE_W-1:0] body_byte;
    logic [PAD_W-1:0]  pad_cnt;
  } plan_t;

endpackage

/* src/rxsd_if.sv */
// ----------------------------------------------------------------------------
// rxsd channel interfaces
// valid/ready channels for input items, result items and configuration
// ----------------------------------------------------------------------------
interface rxsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [rxsd_pkg::BYTE_W-1:0]   in_byte;
  logic                          start_req;
  modport source (output valid, output in_byte, output start_req, input ready);
  modport sink   (input valid, input in_byte, input start_req, output ready);
endinterface

interface rxsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [rxsd_pkg::BYTE_W-1:0]   out_byte;
  logic [rxsd_pkg::KIND_W-1:0]   kind;
  logic                          last;
  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

interface rxsd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rxsd_pkg::PAD_W-1:0]    pad_bytes;
  modport source (output valid, output pad_bytes, input ready);
  modport sink   (input valid, input pad_bytes, output ready);
endinterface

/* src/rxsd_decode.sv */
// ----------------------------------------------------------------------------
// rxsd_decode
// header parse, key roll and body decode; one plan per accepted item
// ----------------------------------------------------------------------------
module rxsd_decode (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic [rxsd_pkg::BYTE_W-1:0]  in_byte,
  input  logic                         start_req,
  input  logic [rxsd_pkg::PAD_W-1:0]   pad_bytes,
  output rxsd_pkg::plan_t              plan
);

  rxsd_pkg::phase_t              phase_r, phase_nxt;
  logic [rxsd_pkg::LEN_W-1:0]    rem_r, rem_nxt;
  logic [rxsd_pkg::NIB_W-1:0]    len_high_r, len_high_nxt;
  logic [rxsd_pkg::BYTE_W-1:0]   key_step_r, key_step_nxt;
  logic [rxsd_pkg::BYTE_W-1:0]   key_run_r, key_run_nxt;
  logic                          hdr_ok;
  logic [rxsd_pkg::LEN_W-1:0]    rem_dec;

  // signed compare against the header limit
  assign hdr_ok  = in_byte[rxsd_pkg::BYTE_W-1] || (in_byte <= rxsd_pkg::HDR_SIGNED_MAX);
  assign rem_dec = rem_r - rxsd_pkg::LEN_W'(1);

  always_comb begin
    phase_nxt    = phase_r;
    rem_nxt      = rem_r;
    len_high_nxt = len_high_r;
    key_step_nxt = key_step_r;
    key_run_nxt  = key_run_r;
    plan         = '0;
    if (start_req) begin
      if (hdr_ok) begin
        len_high_nxt = in_byte[rxsd_pkg::NIB_W-1:0];
        phase_nxt    = rxsd_pkg::PH_HDR1;
      end else begin
        plan.err  = 1'b1;
        phase_nxt = rxsd_pkg::PH_IDLE;
      end
    end else begin
      unique case (phase_r)
        rxsd_pkg::PH_HDR1: begin
          rem_nxt   = {len_high_r, in_byte};
          phase_nxt = rxsd_pkg::PH_HDR2;
        end
        rxsd_pkg::PH_HDR2: begin
          key_run_nxt = in_byte;
          phase_nxt   = rxsd_pkg::PH_HDR3;
        end
        rxsd_pkg::PH_HDR3: begin
          key_step_nxt = in_byte;
          key_run_nxt  = key_run_r + in_byte;
          if (rem_r == '0) begin
            plan.pad_cnt = pad_bytes;
            phase_nxt    = rxsd_pkg::PH_IDLE;
          end else begin
            phase_nxt = rxsd_pkg::PH_BODY;
          end
        end
        rxsd_pkg::PH_BODY: begin
          plan.has_body  = 1'b1;
          plan.body_byte = in_byte ^ key_run_r;
          key_run_nxt    = key_run_r + key_step_r;
          rem_nxt        = rem_dec;
          if (rem_dec == '0) begin
            plan.body_last = 1'b1;
            plan.pad_cnt   = pad_bytes;
            phase_nxt      = rxsd_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_nxt = rxsd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rxsd_pkg::PH_IDLE;
      rem_r      <= '0;
      len_high_r <= '0;
      key_step_r <= '0;
      key_run_r  <= '0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      rem_r      <= rem_nxt;
      len_high_r <= len_high_nxt;
      key_step_r <= key_step_nxt;
      key_run_r  <= key_run_nxt;
    end
  end

endmodule

/* src/rxsd_emit.sv */
// ----------------------------------------------------------------------------
// rxsd_emit
// result register and padding counter; turns a plan into result items
// ----------------------------------------------------------------------------
module rxsd_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rxsd_pkg::plan_t              plan,
  input  logic                         load,
  output logic                         can_load,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rxsd_pkg::BYTE_W-1:0]  out_byte,
  output logic [rxsd_pkg::KIND_W-1:0]  out_kind,
  output logic                         out_last
);

  logic                          valid_r, valid_nxt;
  logic [rxsd_pkg::BYTE_W-1:0]   byte_r, byte_nxt;
  rxsd_pkg::kind_t               kind_r, kind_nxt;
  logic                          last_r, last_nxt;
  logic [rxsd_pkg::PAD_W-1:0]    pads_r, pads_nxt;
  logic                          slot_free;

  assign slot_free = !valid_r || out_ready;
  assign can_load  = (pads_r == '0) && slot_free;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    kind_nxt  = kind_r;
    last_nxt  = last_r;
    pads_nxt  = pads_r;
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    if (pads_r != '0) begin
      if (slot_free) begin
        valid_nxt = 1'b1;
        byte_nxt  = '0;
        kind_nxt  = rxsd_pkg::KIND_PAD;
        last_nxt  = (pads_r == rxsd_pkg::PAD_W'(1));
        pads_nxt  = pads_r - rxsd_pkg::PAD_W'(1);
      end
    end else if (load) begin
      if (plan.err) begin
        valid_nxt = 1'b1;
        byte_nxt  = '0;
        kind_nxt  = rxsd_pkg::KIND_ERR;
        last_nxt  = 1'b1;
      end else if (plan.has_body) begin
        valid_nxt = 1'b1;
        byte_nxt  = plan.body_byte;
        kind_nxt  = rxsd_pkg::KIND_BODY;
        last_nxt  = plan.body_last && (plan.pad_cnt == '0);
        pads_nxt  = plan.pad_cnt;
      end else if (plan.pad_cnt != '0) begin
        valid_nxt = 1'b1;
        byte_nxt  = '0;
        kind_nxt  = rxsd_pkg::KIND_PAD;
        last_nxt  = (plan.pad_cnt == rxsd_pkg::PAD_W'(1));
        pads_nxt  = plan.pad_cnt - rxsd_pkg::PAD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pads_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      pads_r  <= pads_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;

endmodule

/* src/rolling_xor_string_decoder_unit.sv */
// ----------------------------------------------------------------------------
// rolling_xor_string_decoder_unit
// decodes an obfuscated blob byte by byte with a rolling xor key
// ----------------------------------------------------------------------------
// in_ch takes one blob byte per item; start_req marks header byte 0. four
// header bytes carry length and keys, body bytes come out xored with the
// rolling key, then pad_bytes zero items follow and the final result of the
// blob has last set. a rejected header gives one error item.
// out_ch carries result items from a single result register, so a result
// shows in the cycle after its item is accepted.
// throughput is one item per cycle while out_ch takes results; the padding
// counter holds in_ch ready low while it emits pad items after a body. the
// key add and xor sit between the input and the result register.
// cfg_ch writes pad_bytes at any time and is always ready; change it only
// while the block is idle.
// reset clears the header state, the padding counter and the result valid,
// and sets pad_bytes to 1. when out_ch stalls the result register holds and
// in_ch ready drops until the result is taken.
// ----------------------------------------------------------------------------
module rolling_xor_string_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  rxsd_in_if.sink     in_ch,
  rxsd_out_if.source  out_ch,
  rxsd_cfg_if.sink    cfg_ch
);

  logic [rxsd_pkg::PAD_W-1:0] pad_bytes_r;
  rxsd_pkg::plan_t            plan;
  logic                       can_load;
  logic                       take;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_bytes_r <= rxsd_pkg::PAD_RESET;
    end else if (cfg_ch.valid) begin
      pad_bytes_r <= cfg_ch.pad_bytes;
    end
  end

  assign in_ch.ready = can_load;
  assign take        = in_ch.valid && can_load;

  rxsd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_byte   (in_ch.in_byte),
    .start_req (in_ch.start_req),
    .pad_bytes (pad_bytes_r),
    .plan      (plan)
  );

  rxsd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .plan      (plan),
    .load      (take),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_kind  (out_ch.kind),
    .out_last  (out_ch.last)
  );

endmodule
